/* hdl/pixel_channel_format_convert_unit_assert.svh */
// Assertion macros shared by the pixel format converter checker.
// Depends on nothing; included by the checker file.
`ifndef PIXEL_CHANNEL_FORMAT_CONVERT_UNIT_ASSERT_SVH
`define PIXEL_CHANNEL_FORMAT_CONVERT_UNIT_ASSERT_SVH

// Assertion that is checked only outside reset.
`define PCFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked on every edge, reset included.
`define PCFC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pcfc_pkg.sv */
// Package of the pixel format converter: mode codes, word types, constants.
// Depends on nothing; used by the interfaces and all modules.
package pcfc_pkg;

   typedef enum logic [3:0] {
      MODE_COPY1      = 4'd0,
      MODE_COPY3      = 4'd1,
      MODE_COPY4      = 4'd2,
      MODE_GRAY3      = 4'd3,
      MODE_GRAY4      = 4'd4,
      MODE_ADD_ALPHA  = 4'd5,
      MODE_SWAP3      = 4'd6,
      MODE_SWAP4      = 4'd7,
      MODE_DROP_ALPHA = 4'd8,
      MODE_DROP_SWAP  = 4'd9,
      MODE_LUMA_RGB   = 4'd10,
      MODE_LUMA_BGR   = 4'd11,
      MODE_FILL1      = 4'd12,
      MODE_FILL3      = 4'd13,
      MODE_FILL4      = 4'd14
   } mode_type;

   // Register indexes, decoded from the word address.
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_FILL = 1'b1;

   localparam int unsigned CSR_ADDR_WIDTH = 3;

   localparam logic [4:0] LUMA_WR    = 5'd19;
   localparam logic [5:0] LUMA_WG    = 6'd38;
   localparam logic [2:0] LUMA_WB    = 3'd7;
   localparam int unsigned LUMA_SHIFT = 6;
   localparam logic [7:0] OPAQUE     = 8'hFF;

   localparam logic [2:0] COUNT_ONE   = 3'd1;
   localparam logic [2:0] COUNT_THREE = 3'd3;
   localparam logic [2:0] COUNT_FOUR  = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte0;
      logic [7:0] in_byte1;
      logic [7:0] in_byte2;
      logic [7:0] in_byte3;
      logic       last_in;
   } pixel_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [2:0] out_count;
      logic       last_out;
   } result_type;

endpackage

/* hdl/pcfc_if.sv */
// Valid/ready channel interfaces for source pixels and converted pixels.
// Depends on pcfc_pkg for the word types.
interface pcfc_req_if;
   logic                  valid;
   logic                  ready;
   pcfc_pkg::pixel_type   data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pcfc_rsp_if;
   logic                  valid;
   logic                  ready;
   pcfc_pkg::result_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/pcfc_convert.sv */
// Conversion datapath: maps one source pixel to one result word by mode.
// Depends on pcfc_pkg; instantiated by the top level between its registers.
module pcfc_convert (
   input  pcfc_pkg::mode_type   mode,
   input  logic [31:0]          fill_color,
   input  pcfc_pkg::pixel_type  pixel,
   output pcfc_pkg::result_type result
);

   logic [7:0]  luma_r;
   logic [7:0]  luma_b;
   logic [13:0] luma_sum;
   logic [7:0]  luma;

   // The weights sum to 64, so the shifted sum always fits in a byte.
   always_comb begin
      if (mode == pcfc_pkg::MODE_LUMA_BGR) begin
         luma_r = pixel.in_byte2;
         luma_b = pixel.in_byte0;
      end else begin
         luma_r = pixel.in_byte0;
         luma_b = pixel.in_byte2;
      end
      luma_sum = 14'(luma_r) * 14'(pcfc_pkg::LUMA_WR)
               + 14'(pixel.in_byte1) * 14'(pcfc_pkg::LUMA_WG)
               + 14'(luma_b) * 14'(pcfc_pkg::LUMA_WB);
      luma = luma_sum[pcfc_pkg::LUMA_SHIFT +: 8];
   end

   always_comb begin
      result.out_byte0 = pixel.in_byte0;
      result.out_byte1 = '0;
      result.out_byte2 = '0;
      result.out_byte3 = '0;
      result.out_count = pcfc_pkg::COUNT_ONE;
      result.last_out  = pixel.last_in;
      case (mode)
         pcfc_pkg::MODE_COPY3, pcfc_pkg::MODE_DROP_ALPHA: begin
            result.out_byte1 = pixel.in_byte1;
            result.out_byte2 = pixel.in_byte2;
            result.out_count = pcfc_pkg::COUNT_THREE;
         end
         pcfc_pkg::MODE_COPY4: begin
            result.out_byte1 = pixel.in_byte1;
            result.out_byte2 = pixel.in_byte2;
            result.out_byte3 = pixel.in_byte3;
            result.out_count = pcfc_pkg::COUNT_FOUR;
         end
         pcfc_pkg::MODE_GRAY3: begin
            result.out_byte1 = pixel.in_byte0;
            result.out_byte2 = pixel.in_byte0;
            result.out_count = pcfc_pkg::COUNT_THREE;
         end
         pcfc_pkg::MODE_GRAY4: begin
            result.out_byte1 = pixel.in_byte0;
            result.out_byte2 = pixel.in_byte0;
            result.out_byte3 = pcfc_pkg::OPAQUE;
            result.out_count = pcfc_pkg::COUNT_FOUR;
         end
         pcfc_pkg::MODE_ADD_ALPHA: begin
            result.out_byte1 = pixel.in_byte1;
            result.out_byte2 = pixel.in_byte2;
            result.out_byte3 = pcfc_pkg::OPAQUE;
            result.out_count = pcfc_pkg::COUNT_FOUR;
         end
         pcfc_pkg::MODE_SWAP3, pcfc_pkg::MODE_DROP_SWAP: begin
            result.out_byte0 = pixel.in_byte2;
            result.out_byte1 = pixel.in_byte1;
            result.out_byte2 = pixel.in_byte0;
            result.out_count = pcfc_pkg::COUNT_THREE;
         end
         pcfc_pkg::MODE_SWAP4: begin
            result.out_byte0 = pixel.in_byte2;
            result.out_byte1 = pixel.in_byte1;
            result.out_byte2 = pixel.in_byte0;
            result.out_byte3 = pixel.in_byte3;
            result.out_count = pcfc_pkg::COUNT_FOUR;
         end
         pcfc_pkg::MODE_LUMA_RGB, pcfc_pkg::MODE_LUMA_BGR: begin
            result.out_byte0 = luma;
         end
         pcfc_pkg::MODE_FILL1: begin
            result.out_byte0 = fill_color[7:0];
         end
         pcfc_pkg::MODE_FILL3: begin
            result.out_byte0 = fill_color[7:0];
            result.out_byte1 = fill_color[15:8];
            result.out_byte2 = fill_color[23:16];
            result.out_count = pcfc_pkg::COUNT_THREE;
         end
         pcfc_pkg::MODE_FILL4: begin
            result.out_byte0 = fill_color[7:0];
            result.out_byte1 = fill_color[15:8];
            result.out_byte2 = fill_color[23:16];
            result.out_byte3 = fill_color[31:24];
            result.out_count = pcfc_pkg::COUNT_FOUR;
         end
         // Copy one byte, and the unused code behaves the same.
         default: begin
            result.out_byte0 = pixel.in_byte0;
         end
      endcase
   end

endmodule

/* hdl/pixel_channel_format_convert_unit.sv */
// Pixel channel format converter: input register, conversion, result register.
// Depends on pcfc_pkg, pcfc_if and pcfc_convert.
//
// The unit converts one pixel word per clock while the result side is not
// stalled. A word accepted on req_chan is held in the input register, goes
// through the single conversion stage that sits between the input register and
// the result register, and is presented on rsp_chan from the result register.
// The input side stays ready while a result waits, as long as the input register
// is free or moves on in the same cycle. The mode and fill color registers are
// read as each word enters the result register, so they must be written only
// while no word is inside the unit.
module pixel_channel_format_convert_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   pcfc_req_if.sink                              req_chan,
   pcfc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pcfc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   pcfc_pkg::mode_type   mode_ff;
   logic [31:0]          fill_ff;
   logic                 csr_write;
   logic                 s1_valid_ff, s1_valid_in;
   pcfc_pkg::pixel_type  s1_pixel_ff;
   logic                 s2_valid_ff, s2_valid_in;
   pcfc_pkg::result_type s2_result_ff;
   pcfc_pkg::result_type conv_result;
   logic                 req_take;
   logic                 s2_load;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      if (csr_paddr[2] == pcfc_pkg::REG_FILL) begin
         csr_prdata = fill_ff;
      end else begin
         csr_prdata = {28'd0, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pcfc_pkg::MODE_COPY1;
         fill_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == pcfc_pkg::REG_FILL) begin
            fill_ff <= csr_pwdata;
         end else begin
            mode_ff <= pcfc_pkg::mode_type'(csr_pwdata[3:0]);
         end
      end
   end

   // The result register loads when the input register holds a word and it is empty or being drained.
   assign s2_load        = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s2_load;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= req_chan.data;
      end
      if (s2_load) begin
         s2_result_ff <= conv_result;
      end
   end

   pcfc_convert u_convert (
      .mode       (mode_ff),
      .fill_color (fill_ff),
      .pixel      (s1_pixel_ff),
      .result     (conv_result)
   );

   assign rsp_chan.valid = s2_valid_ff;
   assign rsp_chan.data  = s2_result_ff;

endmodule

/* hdl/pcfc_checker.sv */
// Port-level checks on the result channel of the pixel format converter.
// Depends on the assertion macro header and pcfc_pkg; bound to the top level below.
`include "pixel_channel_format_convert_unit_assert.svh"

module pcfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte1,
   input logic [7:0] rsp_byte2,
   input logic [7:0] rsp_byte3,
   input logic [2:0] rsp_count
);

   logic rsp_stalled;
   logic count_legal;
   logic unused_zero;

   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign count_legal = rsp_count == pcfc_pkg::COUNT_ONE || rsp_count == pcfc_pkg::COUNT_THREE
                        || rsp_count == pcfc_pkg::COUNT_FOUR;
   // Bytes past the count must be zero; a three-byte word only clears the last one.
   assign unused_zero = rsp_count == pcfc_pkg::COUNT_FOUR
                        || (rsp_byte3 == 8'd0 && (rsp_count == pcfc_pkg::COUNT_THREE
                            || (rsp_byte1 == 8'd0 && rsp_byte2 == 8'd0)));

   `PCFC_ASSERT(a_rsp_hold, clock, reset, rsp_stalled |=> rsp_valid, "stalled word dropped")
   `PCFC_ASSERT(a_count_legal, clock, reset, rsp_valid |-> count_legal, "illegal byte count")
   `PCFC_ASSERT(a_unused_zero, clock, reset, rsp_valid |-> unused_zero, "unused byte not zero")
   `PCFC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "valid after reset")

endmodule

bind pixel_channel_format_convert_unit pcfc_checker u_pcfc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_byte1 (rsp_chan.data.out_byte1),
   .rsp_byte2 (rsp_chan.data.out_byte2),
   .rsp_byte3 (rsp_chan.data.out_byte3),
   .rsp_count (rsp_chan.data.out_count)
);

/* verif/tb.sv */
// Self-checking testbench for the pixel channel format converter.
// Depends on pcfc_pkg and the pcfc_req_if/pcfc_rsp_if channel interfaces.
// Drives random pixel words under many mode/fill settings and checks every result word.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS = 1450;
   localparam int unsigned LONG_HOLD    = 150;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned MAX_PRINTS   = 30;

   localparam logic [pcfc_pkg::CSR_ADDR_WIDTH-1:0] ADDR_MODE = {pcfc_pkg::REG_MODE, 2'b00};
   localparam logic [pcfc_pkg::CSR_ADDR_WIDTH-1:0] ADDR_FILL = {pcfc_pkg::REG_FILL, 2'b00};

   // Keeps its own copy of the registers and the queue of expected result words.
   class pixel_scoreboard;
      logic [3:0]           mode;
      logic [31:0]          fill;
      pcfc_pkg::result_type expected_pixels[$];
      int unsigned          mismatches;
      int unsigned          converted;

      function new();
         mode = 4'd0;
         fill = 32'd0;
         mismatches = 0;
         converted = 0;
      endfunction

      function void set_register(logic index, logic [31:0] value);
         if (index == pcfc_pkg::REG_MODE) begin
            mode = value[3:0];
         end else begin
            fill = value;
         end
      endfunction

      function logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned sum;
         sum = 19 * r + 38 * g + 7 * b;
         return sum[13:6];
      endfunction

      function pcfc_pkg::result_type convert_pixel(pcfc_pkg::pixel_type px);
         pcfc_pkg::result_type res;
         res = '0;
         res.last_out = px.last_in;
         case (mode)
            pcfc_pkg::MODE_COPY3, pcfc_pkg::MODE_DROP_ALPHA: begin
               {res.out_byte0, res.out_byte1, res.out_byte2} =
                  {px.in_byte0, px.in_byte1, px.in_byte2};
               res.out_count = 3'd3;
            end
            pcfc_pkg::MODE_COPY4: begin
               {res.out_byte0, res.out_byte1, res.out_byte2, res.out_byte3} =
                  {px.in_byte0, px.in_byte1, px.in_byte2, px.in_byte3};
               res.out_count = 3'd4;
            end
            pcfc_pkg::MODE_GRAY3: begin
               {res.out_byte0, res.out_byte1, res.out_byte2} =
                  {px.in_byte0, px.in_byte0, px.in_byte0};
               res.out_count = 3'd3;
            end
            pcfc_pkg::MODE_GRAY4: begin
               {res.out_byte0, res.out_byte1, res.out_byte2, res.out_byte3} =
                  {px.in_byte0, px.in_byte0, px.in_byte0, 8'hFF};
               res.out_count = 3'd4;
            end
            pcfc_pkg::MODE_ADD_ALPHA: begin
               {res.out_byte0, res.out_byte1, res.out_byte2, res.out_byte3} =
                  {px.in_byte0, px.in_byte1, px.in_byte2, 8'hFF};
               res.out_count = 3'd4;
            end
            pcfc_pkg::MODE_SWAP3, pcfc_pkg::MODE_DROP_SWAP: begin
               {res.out_byte0, res.out_byte1, res.out_byte2} =
                  {px.in_byte2, px.in_byte1, px.in_byte0};
               res.out_count = 3'd3;
            end
            pcfc_pkg::MODE_SWAP4: begin
               {res.out_byte0, res.out_byte1, res.out_byte2, res.out_byte3} =
                  {px.in_byte2, px.in_byte1, px.in_byte0, px.in_byte3};
               res.out_count = 3'd4;
            end
            pcfc_pkg::MODE_LUMA_RGB: begin
               res.out_byte0 = luma(px.in_byte0, px.in_byte1, px.in_byte2);
               res.out_count = 3'd1;
            end
            pcfc_pkg::MODE_LUMA_BGR: begin
               res.out_byte0 = luma(px.in_byte2, px.in_byte1, px.in_byte0);
               res.out_count = 3'd1;
            end
            pcfc_pkg::MODE_FILL1: begin
               res.out_byte0 = fill[7:0];
               res.out_count = 3'd1;
            end
            pcfc_pkg::MODE_FILL3: begin
               {res.out_byte0, res.out_byte1, res.out_byte2} =
                  {fill[7:0], fill[15:8], fill[23:16]};
               res.out_count = 3'd3;
            end
            pcfc_pkg::MODE_FILL4: begin
               {res.out_byte0, res.out_byte1, res.out_byte2, res.out_byte3} =
                  {fill[7:0], fill[15:8], fill[23:16], fill[31:24]};
               res.out_count = 3'd4;
            end
            // The unused mode code falls back to a one-byte copy.
            default: begin
               res.out_byte0 = px.in_byte0;
               res.out_count = 3'd1;
            end
         endcase
         return res;
      endfunction

      function void note_pixel(pcfc_pkg::pixel_type px);
         expected_pixels.push_back(convert_pixel(px));
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      task report(string what);
         if (mismatches < MAX_PRINTS) begin
            $display("%0t ns MISMATCH: %s", $realtime, what);
         end
         mismatches++;
      endtask

      task check_field(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want) begin
            report($sformatf("word %0d %s got %0h expected %0h", converted, field, got, want));
         end
      endtask

      task check_result(pcfc_pkg::result_type got);
         pcfc_pkg::result_type want;
         if (expected_pixels.size() == 0) begin
            report($sformatf("result word %0h with nothing expected", got));
         end else begin
            want = expected_pixels.pop_front();
            check_field("out_byte0", got.out_byte0, want.out_byte0);
            check_field("out_byte1", got.out_byte1, want.out_byte1);
            check_field("out_byte2", got.out_byte2, want.out_byte2);
            check_field("out_byte3", got.out_byte3, want.out_byte3);
            check_field("out_count", 8'(got.out_count), 8'(want.out_count));
            check_field("last_out", 8'(got.last_out), 8'(want.last_out));
            converted++;
         end
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [pcfc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]                         csr_pwdata;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   pcfc_req_if req_chan();
   pcfc_rsp_if rsp_chan();

   pixel_scoreboard sb = new();

   int unsigned cycles;
   int unsigned stall_cycles;
   int unsigned words_sent;
   int unsigned settings;
   bit          hold_request;

   pixel_channel_format_convert_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Accepted words on both sides; outputs are sampled before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_pixel(req_chan.data);
         end
         if (req_chan.valid && !req_chan.ready) begin
            stall_cycles++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.data);
         end
      end
   end

   // Result side back-pressure: changing stall styles, plus one long hold on request.
   initial begin
      int unsigned style;
      int unsigned style_left;
      int unsigned hold_left;
      int unsigned beat;
      style = 0;
      style_left = 0;
      hold_left = 0;
      beat = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         beat++;
         if (hold_left == 0 && hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 3);
               style_left = $urandom_range(8, 80);
            end
            style_left--;
            case (style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_chan.ready <= ((beat % 7) < 3);
            endcase
         end
      end
   end

   function pcfc_pkg::pixel_type make_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, logic last);
      pcfc_pkg::pixel_type px;
      px.in_byte0 = b0;
      px.in_byte1 = b1;
      px.in_byte2 = b2;
      px.in_byte3 = b3;
      px.last_in = last;
      return px;
   endfunction

   function logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function pcfc_pkg::pixel_type random_pixel();
      return make_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                        $urandom_range(0, 3) == 0);
   endfunction

   // Holds the word on the channel until it is accepted; valid stays high afterwards.
   task send_pixel(pcfc_pkg::pixel_type px);
      req_chan.valid <= 1'b1;
      req_chan.data <= px;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task send_stream(int unsigned total, bit back_to_back);
      int unsigned left;
      int unsigned burst;
      int unsigned gap;
      left = total;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) begin
            burst = left;
         end
         repeat (burst) send_pixel(random_pixel());
         left -= burst;
         gap = (back_to_back || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops sending and waits until every expected word has come back.
   task drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task csr_access(logic write, logic [pcfc_pkg::CSR_ADDR_WIDTH-1:0] addr,
                   logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task read_back(logic index);
      logic [31:0] rdata;
      logic [31:0] want;
      csr_access(1'b0, (index == pcfc_pkg::REG_MODE) ? ADDR_MODE : ADDR_FILL, 32'd0, rdata);
      want = (index == pcfc_pkg::REG_MODE) ? {28'd0, sb.mode} : sb.fill;
      if (rdata !== want) begin
         sb.report($sformatf("register %0d read %0h expected %0h", index, rdata, want));
      end
   endtask

   task program_register(logic index, logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, (index == pcfc_pkg::REG_MODE) ? ADDR_MODE : ADDR_FILL, value, unused);
      sb.set_register(index, value);
      read_back(index);
   endtask

   initial begin
      int unsigned m;
      int unsigned phase;
      int unsigned random_sent;
      int unsigned phase_len;
      logic [31:0] fill_word;

      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers come out of reset as zero; the first word uses the reset mode.
      read_back(pcfc_pkg::REG_MODE);
      read_back(pcfc_pkg::REG_FILL);
      send_pixel(make_pixel(8'hFF, 8'h00, 8'h5A, 8'hA5, 1'b1));
      drain();

      // One word per mode code with distinct bytes, so any swap shows; luma gets its extremes.
      program_register(pcfc_pkg::REG_FILL, 32'hFF00A55A);
      for (m = 0; m < 16; m++) begin
         program_register(pcfc_pkg::REG_MODE, m);
         settings++;
         send_pixel(make_pixel(8'hFF, 8'h00, 8'h5A, 8'hA5, m[0]));
         if (m == pcfc_pkg::MODE_LUMA_RGB || m == pcfc_pkg::MODE_LUMA_BGR) begin
            send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
            send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
         end
         drain();
      end

      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 3))
            0: fill_word = 32'h0000_0000;
            1: fill_word = 32'hFFFF_FFFF;
            default: fill_word = $urandom;
         endcase
         program_register(pcfc_pkg::REG_FILL, fill_word);
         m = $urandom_range(0, 15);
         // Upper data bits are sometimes set; only the low nibble is the mode.
         program_register(pcfc_pkg::REG_MODE,
                          ($urandom_range(0, 1) ? ($urandom & 32'hFFFF_FFF0) : 0) | m);
         settings++;
         phase_len = (phase == 2) ? 60 : $urandom_range(30, 110);
         if (phase_len > RANDOM_WORDS - random_sent) begin
            phase_len = RANDOM_WORDS - random_sent;
         end
         if (phase == 2) begin
            // Stall the result side for a long stretch while words keep coming.
            hold_request = 1'b1;
            send_stream(phase_len, 1'b1);
         end else begin
            send_stream(phase_len, 1'b0);
         end
         random_sent += phase_len;
         drain();
         phase++;
      end

      repeat (10) @(posedge clock);
      $display("Run covered %0d pixel words over %0d register settings, every mode code,",
               words_sent, settings);
      $display("with fill extremes and %0d cycles of input held off by output stalls.",
               stall_cycles);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d words never arrived", sb.mismatches, sb.pending());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
